FILE: hw/rtl/rc4sc_pkg.sv
// rc4sc_pkg: shared constants, codes and helpers of the rc4 cipher engine
// no dependencies; used by the interfaces, the engine and its checker
package rc4sc_pkg;

    // key storage
    localparam int MAX_KEY_BYTES = 16;
    localparam int KEY_LEN_W     = 5;
    localparam int KEY_WORD_W    = 64;
    localparam int KPOS_W        = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    // permutation table
    localparam int PERM_W     = 8;
    localparam int PERM_DEPTH = 256;
    localparam int PERM_AW    = $clog2(PERM_DEPTH);

    // request payload
    localparam int DATA_W = 8;

    // configuration port
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LEN  = 2'd0,
        CFG_KEY_LOW  = 2'd1,
        CFG_KEY_HIGH = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        FUNC_REKEY = 1'b0,
        FUNC_CRYPT = 1'b1
    } t_func;

    // key length with zero taken as one and saturation at the key store size
    function automatic logic [KEY_LEN_W-1:0] eff_key_len(input logic [KEY_LEN_W-1:0] len);
        logic [KEY_LEN_W-1:0] res;
        res = len;
        if (len == '0) begin
            res = KEY_LEN_W'(1);
        end
        if (len > KEY_LEN_W'(MAX_KEY_BYTES)) begin
            res = KEY_LEN_W'(MAX_KEY_BYTES);
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/rc4sc_in_if.sv
// rc4sc_in_if: request channel of the rc4 engine (func, data byte)
// depends on rc4sc_pkg
interface rc4sc_in_if;
    import rc4sc_pkg::*;

    logic                valid;
    logic                ready;
    logic                func;
    logic [DATA_W-1:0]   data_in;

    modport source (output valid, output func, output data_in, input ready);
    modport sink   (input valid, input func, input data_in, output ready);
endinterface

FILE: hw/rtl/rc4sc_out_if.sv
// rc4sc_out_if: result channel of the rc4 engine (data byte, rekey flag)
// depends on rc4sc_pkg
interface rc4sc_out_if;
    import rc4sc_pkg::*;

    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   data_out;
    logic                rekey_done;

    modport source (output valid, output data_out, output rekey_done, input ready);
    modport sink   (input valid, input data_out, input rekey_done, output ready);
endinterface

FILE: hw/rtl/rc4sc_ram.sv
// rc4sc_ram: generic single write, single read ram with registered read data
// no dependencies
module rc4sc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/rc4_stream_cipher.sv
// rc4_stream_cipher: rc4 key schedule and keystream engine, permutation in one ram
// crypt: a request runs through S_CR_A, S_CR_B and S_CR_C to its result register;
// the next is taken only back in idle, set by the single read port of the ram
// rekey: identity load of all 256 entries, then one swap per entry, S_KS_RD to S_KS_W
// reset: synchronous, then an identity sweep of all 256 ram entries with ready low
// depends on rc4sc_pkg, rc4sc_in_if, rc4sc_out_if, rc4sc_ram
module rc4_stream_cipher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    rc4sc_in_if.sink                            i_req,
    rc4sc_out_if.source                         o_rsp,
    input  logic                                i_cfg_we,
    input  logic [rc4sc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rc4sc_pkg::KEY_WORD_W-1:0]    i_cfg_data
);
    import rc4sc_pkg::*;

    typedef enum logic [10:0] {
        S_INIT    = 11'b000_0000_0001,
        S_IDLE    = 11'b000_0000_0010,
        S_CR_A    = 11'b000_0000_0100,
        S_CR_B    = 11'b000_0000_1000,
        S_CR_C    = 11'b000_0001_0000,
        S_KS_LOAD = 11'b000_0010_0000,
        S_KS_RD   = 11'b000_0100_0000,
        S_KS_A    = 11'b000_1000_0000,
        S_KS_B    = 11'b001_0000_0000,
        S_KS_W    = 11'b010_0000_0000,
        S_PUT     = 11'b100_0000_0000
    } t_state;

    t_state                              r_state, n_state;
    logic [PERM_AW-1:0]                  r_i, n_i;
    logic [PERM_AW-1:0]                  r_j, n_j;
    logic [PERM_AW-1:0]                  r_n, n_n;
    logic [PERM_W-1:0]                   r_a, n_a;
    logic [PERM_W-1:0]                   r_b, n_b;
    logic [PERM_AW-1:0]                  r_t, n_t;
    logic [DATA_W-1:0]                   r_data, n_data;
    logic [KPOS_W-1:0]                   r_kpos, n_kpos;
    logic [DATA_W-1:0]                   r_res, n_res;
    logic                                r_res_done, n_res_done;

    logic [KEY_LEN_W-1:0]                r_key_len;
    logic [KEY_WORD_W-1:0]               r_key_low;
    logic [KEY_WORD_W-1:0]               r_key_high;

    logic                                r_ov;
    logic [DATA_W-1:0]                   r_od;
    logic                                r_odone;

    logic                                ram_we;
    logic [PERM_AW-1:0]                  ram_waddr;
    logic [PERM_W-1:0]                   ram_wdata;
    logic [PERM_AW-1:0]                  ram_raddr;
    logic [PERM_W-1:0]                   ram_rdata;

    logic                                accept;
    logic                                out_free;
    logic                                ld_out;
    logic [DATA_W-1:0]                   ld_data;
    logic                                ld_done;
    logic [MAX_KEY_BYTES-1:0][7:0]       key_all;
    logic [DATA_W-1:0]                   key_byte;
    logic [KEY_LEN_W-1:0]                key_len_eff;
    logic [PERM_AW-1:0]                  ks_sum;
    logic [PERM_W-1:0]                   ks_byte;

    // permutation table
    rc4sc_ram #(
        .WIDTH (PERM_W),
        .DEPTH (PERM_DEPTH)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // handshake
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_ov || o_rsp.ready;

    // key byte selection for the schedule
    assign key_all     = {r_key_high, r_key_low};
    assign key_byte    = key_all[r_kpos];
    assign key_len_eff = eff_key_len(r_key_len);
    assign ks_sum      = r_j + ram_rdata + key_byte;

    // keystream byte after the swap: the later write to j wins over i
    always_comb begin
        priority if (r_t == r_j) begin
            ks_byte = r_a;
        end else if (r_t == r_i) begin
            ks_byte = r_b;
        end else begin
            ks_byte = ram_rdata;
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_n        = r_n;
        n_a        = r_a;
        n_b        = r_b;
        n_t        = r_t;
        n_data     = r_data;
        n_kpos     = r_kpos;
        n_res      = r_res;
        n_res_done = r_res_done;
        ram_we     = 1'b0;
        ram_waddr  = r_n;
        ram_wdata  = r_n;
        ram_raddr  = r_i + PERM_AW'(1);
        ld_out     = 1'b0;
        ld_data    = '0;
        ld_done    = 1'b0;

        unique case (r_state)
            S_INIT: begin
                ram_we = 1'b1;
                n_n    = r_n + PERM_AW'(1);
                if (r_n == PERM_AW'(PERM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ram_raddr = r_i + PERM_AW'(1);
                if (accept) begin
                    n_data = i_req.data_in;
                    if (i_req.func == FUNC_CRYPT) begin
                        n_state = S_CR_A;
                    end else begin
                        n_n     = '0;
                        n_state = S_KS_LOAD;
                    end
                end
            end
            // a = perm[i+1], fetch perm[j+a]
            S_CR_A: begin
                n_a       = ram_rdata;
                n_i       = r_i + PERM_AW'(1);
                n_j       = r_j + ram_rdata;
                ram_raddr = r_j + ram_rdata;
                n_state   = S_CR_B;
            end
            // b arrives: write perm[i] = b, fetch perm[a+b]
            S_CR_B: begin
                n_b       = ram_rdata;
                ram_we    = 1'b1;
                ram_waddr = r_i;
                ram_wdata = ram_rdata;
                ram_raddr = r_a + ram_rdata;
                n_t       = r_a + ram_rdata;
                n_state   = S_CR_C;
            end
            // write perm[j] = a, produce the result
            S_CR_C: begin
                ram_we     = 1'b1;
                ram_waddr  = r_j;
                ram_wdata  = r_a;
                n_res      = ks_byte ^ r_data;
                n_res_done = 1'b0;
                if (out_free) begin
                    ld_out  = 1'b1;
                    ld_data = ks_byte ^ r_data;
                    ld_done = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PUT;
                end
            end
            // identity load before the swaps
            S_KS_LOAD: begin
                ram_we = 1'b1;
                n_n    = r_n + PERM_AW'(1);
                if (r_n == PERM_AW'(PERM_DEPTH - 1)) begin
                    n_j     = '0;
                    n_kpos  = '0;
                    n_state = S_KS_RD;
                end
            end
            S_KS_RD: begin
                ram_raddr = r_n;
                n_state   = S_KS_A;
            end
            // held = perm[n], j += held + key byte, fetch perm[j]
            S_KS_A: begin
                n_a       = ram_rdata;
                n_j       = ks_sum;
                ram_raddr = ks_sum;
                if ((KEY_LEN_W'(r_kpos) + KEY_LEN_W'(1)) >= key_len_eff) begin
                    n_kpos = '0;
                end else begin
                    n_kpos = r_kpos + KPOS_W'(1);
                end
                n_state = S_KS_B;
            end
            S_KS_B: begin
                ram_we    = 1'b1;
                ram_waddr = r_n;
                ram_wdata = ram_rdata;
                n_state   = S_KS_W;
            end
            S_KS_W: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = r_a;
                n_n       = r_n + PERM_AW'(1);
                if (r_n == PERM_AW'(PERM_DEPTH - 1)) begin
                    n_i        = '0;
                    n_j        = '0;
                    n_res      = '0;
                    n_res_done = 1'b1;
                    if (out_free) begin
                        ld_out  = 1'b1;
                        ld_data = '0;
                        ld_done = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_PUT;
                    end
                end else begin
                    n_state = S_KS_RD;
                end
            end
            // result waits for a free output register
            S_PUT: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    ld_data = r_res;
                    ld_done = r_res_done;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_n     = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_i     <= '0;
            r_j     <= '0;
            r_n     <= '0;
            r_kpos  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_n     <= n_n;
            r_kpos  <= n_kpos;
            if (ld_out) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_t        <= n_t;
        r_data     <= n_data;
        r_res      <= n_res;
        r_res_done <= n_res_done;
        if (ld_out) begin
            r_od    <= ld_data;
            r_odone <= ld_done;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len  <= KEY_LEN_W'(MAX_KEY_BYTES);
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_LEN:  r_key_len  <= i_cfg_data[KEY_LEN_W-1:0];
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_rsp.valid      = r_ov;
    assign o_rsp.data_out   = r_od;
    assign o_rsp.rekey_done = r_odone;
endmodule

FILE: hw/rtl/rc4sc_checker.sv
// rc4sc_checker: port-level assertions for the rc4 engine, bound to the top level
// depends on rc4sc_pkg and rc4_stream_cipher
module rc4sc_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    input  logic                         i_req_ready,
    input  logic                         i_rsp_valid,
    input  logic                         i_rsp_ready,
    input  logic [rc4sc_pkg::DATA_W-1:0] i_rsp_data_out,
    input  logic                         i_rsp_rekey_done
);
    import rc4sc_pkg::*;

    // a stalled result holds its value
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_data_out) && $stable(i_rsp_rekey_done))
        else $error("stalled result changed");

    // a rekey acknowledge carries a zero data byte
    a_rekey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_rekey_done |-> i_rsp_data_out == '0)
        else $error("rekey result with nonzero data");

    // one request at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted back to back");

    // no request taken when reset has just been applied, as the table sweep begins
    a_init_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready)
        else $error("ready high right after reset");

    // a result never directly follows an accept that found no result pending
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && !i_rsp_valid |=> !i_rsp_valid)
        else $error("result appeared too early");
endmodule

bind rc4_stream_cipher rc4sc_checker u_rc4sc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_data_out   (o_rsp.data_out),
    .i_rsp_rekey_done (o_rsp.rekey_done)
);
